// ===== hdl/j1587_pkg.sv =====
// ----------------------------------------------------------------------------
// j1587_pkg
// Shared constants, codes and lookup functions of the J1587 message framer.
// ----------------------------------------------------------------------------
package j1587_pkg;

    localparam int MAX_LEN_DEFAULT = 21;

    localparam logic [7:0] SYNC_MID_RESET = 8'd130;
    localparam logic [7:0] SYNC_PID_RESET = 8'd191;

    // configuration register indexes
    localparam int          CFG_IDX_W    = 2;
    localparam logic [1:0]  CFG_SYNC_MID = 2'd0;
    localparam logic [1:0]  CFG_SYNC_PID = 2'd1;

    // result kinds
    localparam logic KIND_MSG = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // framing error codes
    localparam logic [1:0] ERR_UNKNOWN_MID = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_PID = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG    = 2'd2;

    // number of data bytes following a pid, zero for an unknown pid
    function automatic logic [2:0] pid_len(input logic [7:0] p);
        logic [2:0] n;
        unique case (p) inside
            8'd2, 8'd44, 8'd47, 8'd48, 8'd49, 8'd51, 8'd65, 8'd68,
            8'd70, 8'd71, 8'd77, 8'd78, 8'd83, 8'd84, 8'd85, 8'd86,
            8'd89, 8'd91, 8'd92, 8'd93, 8'd96, 8'd100, 8'd102,
            8'd103, 8'd105, 8'd106, 8'd108, 8'd110, 8'd111, 8'd120,
            8'd121, 8'd194, 8'd255:
                n = 3'd1;
            8'd128, 8'd151, 8'd158, 8'd162, 8'd163, 8'd168, 8'd171,
            8'd172, 8'd173, 8'd174, 8'd175, 8'd177, 8'd182, 8'd183,
            8'd184, 8'd185, 8'd187, 8'd190, 8'd191:
                n = 3'd2;
            8'd228, 8'd235, 8'd236, 8'd244, 8'd245, 8'd247, 8'd248,
            8'd250, 8'd254:
                n = 3'd5;
            default:
                n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic mid_known(input logic [7:0] b);
        logic k;
        unique case (b) inside
            8'd128, 8'd130, 8'd136, 8'd140, 8'd142, 8'd179, 8'd219: k = 1'b1;
            default: k = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/j1587_message_framer_core.sv =====
// ----------------------------------------------------------------------------
// j1587_message_framer_core
// Hunts for a sync frame, then frames J1587 messages into a buffer memory and
// drains each closed message as a run of bytes; framing faults give an error.
// ----------------------------------------------------------------------------
// A received byte is taken whenever no message is being drained and the
// output register is free or being emptied. Bytes are written into a
// single-port message buffer as they arrive. When a checksum closes a message
// of n bytes the input is held while the buffer is read back: each byte is
// read in ST_RD and then loaded into the output register in ST_LOAD, which
// waits while the output stalls. An error result goes straight to the
// output register. There is no clearing pass; only entries written by the
// current message are read back.
module j1587_message_framer_core #(
    parameter int MAX_LEN = j1587_pkg::MAX_LEN_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // received bytes
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,
    // results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_kind,
    output logic [7:0]                     o_out_byte,
    output logic                           o_is_pid,
    output logic [1:0]                     o_error_code,
    output logic                           o_last,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [j1587_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    localparam int AW = $clog2(MAX_LEN);
    // the incremented count reaches MAX_LEN + 1 in a sync frame and must hold 18
    localparam int CW = ($clog2(MAX_LEN + 2) > 5) ? $clog2(MAX_LEN + 2) : 5;

    typedef enum logic [2:0] {
        M_HUNT_MID,
        M_HUNT_PID,
        M_SYNC_BODY,
        M_FRAME_MID,
        M_FRAME_BODY
    } t_mode;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RD,
        ST_LOAD
    } t_state;

    t_mode        r_mode, n_mode;
    t_state       r_state;
    logic [7:0]   r_sum, n_sum;
    logic [CW-1:0] r_cnt, n_cnt;
    logic         r_in_data, n_in_data;
    logic [2:0]   r_left, n_left;
    logic [7:0]   r_sync_mid, r_sync_pid;

    logic [8:0]   r_mem [MAX_LEN];
    logic [8:0]   r_rd_data;
    logic [AW-1:0] r_rd_addr;
    logic [AW-1:0] r_drain_last;

    logic         r_out_valid;
    logic         r_out_kind;
    logic [7:0]   r_out_byte;
    logic         r_out_is_pid;
    logic [1:0]   r_out_err;
    logic         r_out_last;

    logic         out_take, out_free, in_acc;
    logic         mem_we;
    logic [AW-1:0] mem_waddr;
    logic [8:0]   mem_wdata;
    logic         err_fire, close_fire;
    logic [1:0]   err_code;
    logic [7:0]   chk;
    logic [CW-1:0] cnt_inc;
    logic [2:0]   plen;
    logic         drain_load, drain_end;

    assign out_take   = r_out_valid && !i_out_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_RUN) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign chk     = 8'h00 - r_sum;
    assign cnt_inc = r_cnt + CW'(1);
    assign plen    = j1587_pkg::pid_len(i_rx_byte);

    assign drain_load = (r_state == ST_LOAD) && out_free;
    assign drain_end  = drain_load && (r_rd_addr == r_drain_last);

    always_comb begin
        n_mode     = r_mode;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_in_data  = r_in_data;
        n_left     = r_left;
        mem_we     = 1'b0;
        mem_waddr  = r_cnt[AW-1:0];
        mem_wdata  = {1'b0, i_rx_byte};
        err_fire   = 1'b0;
        err_code   = j1587_pkg::ERR_UNKNOWN_MID;
        close_fire = 1'b0;
        if (in_acc) begin
            unique case (r_mode)
                M_HUNT_PID: begin
                    if (i_rx_byte != r_sync_pid) begin
                        n_mode = M_HUNT_MID;
                        n_sum  = 8'd0;
                        n_cnt  = '0;
                    end else begin
                        n_mode = M_SYNC_BODY;
                        n_sum  = r_sum + i_rx_byte;
                        n_cnt  = CW'(2);
                    end
                end
                M_SYNC_BODY: begin
                    n_cnt = cnt_inc;
                    if (chk == i_rx_byte && (cnt_inc == CW'(5) || cnt_inc == CW'(11))) begin
                        n_mode = M_FRAME_MID;
                        n_sum  = 8'd0;
                        n_cnt  = '0;
                    end else if (cnt_inc > CW'(MAX_LEN)) begin
                        n_mode = M_HUNT_MID;
                        n_sum  = 8'd0;
                        n_cnt  = '0;
                    end else begin
                        n_sum = r_sum + i_rx_byte;
                    end
                end
                M_FRAME_MID: begin
                    if (!j1587_pkg::mid_known(i_rx_byte)) begin
                        err_fire = 1'b1;
                        err_code = j1587_pkg::ERR_UNKNOWN_MID;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        n_cnt     = CW'(1);
                        n_sum     = i_rx_byte;
                        n_in_data = 1'b0;
                        n_left    = 3'd0;
                        n_mode    = M_FRAME_BODY;
                    end
                end
                M_FRAME_BODY: begin
                    if (r_in_data && r_left != 3'd0) begin
                        n_left = r_left - 3'd1;
                    end
                    if (r_cnt >= CW'(MAX_LEN)) begin
                        err_fire = 1'b1;
                        err_code = j1587_pkg::ERR_TOO_LONG;
                    end else if (!r_in_data && chk == i_rx_byte && r_cnt != CW'(18)) begin
                        // checksum closes the message, drain it
                        mem_we     = 1'b1;
                        close_fire = 1'b1;
                        n_mode     = M_FRAME_MID;
                        n_sum      = 8'd0;
                        n_cnt      = '0;
                        n_in_data  = 1'b0;
                        n_left     = 3'd0;
                    end else begin
                        mem_we    = 1'b1;
                        mem_wdata = {!r_in_data, i_rx_byte};
                        n_cnt     = cnt_inc;
                        n_sum     = r_sum + i_rx_byte;
                        if (!r_in_data) begin
                            if (plen == 3'd0) begin
                                err_fire = 1'b1;
                                err_code = j1587_pkg::ERR_UNKNOWN_PID;
                            end else begin
                                n_in_data = 1'b1;
                                n_left    = plen;
                            end
                        end
                        if (n_left == 3'd0) begin
                            n_in_data = 1'b0;
                        end
                    end
                end
                default: begin
                    if (i_rx_byte == r_sync_mid) begin
                        n_mode = M_HUNT_PID;
                        n_sum  = i_rx_byte;
                        n_cnt  = CW'(1);
                    end else begin
                        n_mode = M_HUNT_MID;
                    end
                end
            endcase
            if (err_fire) begin
                n_mode    = M_HUNT_MID;
                n_sum     = 8'd0;
                n_cnt     = '0;
                n_in_data = 1'b0;
                n_left    = 3'd0;
            end
        end
    end

    // message buffer, written while framing and read back while draining
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_RD) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_HUNT_MID;
            r_state      <= ST_RUN;
            r_sum        <= 8'd0;
            r_cnt        <= '0;
            r_in_data    <= 1'b0;
            r_left       <= 3'd0;
            r_sync_mid   <= j1587_pkg::SYNC_MID_RESET;
            r_sync_pid   <= j1587_pkg::SYNC_PID_RESET;
            r_rd_addr    <= '0;
            r_drain_last <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_sum     <= n_sum;
            r_cnt     <= n_cnt;
            r_in_data <= n_in_data;
            r_left    <= n_left;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    j1587_pkg::CFG_SYNC_MID: r_sync_mid <= i_cfg_data;
                    j1587_pkg::CFG_SYNC_PID: r_sync_pid <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_RUN: begin
                    if (close_fire) begin
                        r_state      <= ST_RD;
                        r_rd_addr    <= '0;
                        r_drain_last <= r_cnt[AW-1:0];
                    end
                end
                ST_RD: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (drain_end) begin
                        r_state <= ST_RUN;
                    end else if (drain_load) begin
                        r_state   <= ST_RD;
                        r_rd_addr <= r_rd_addr + AW'(1);
                    end
                end
                default: r_state <= ST_RUN;
            endcase

            if (drain_load) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= j1587_pkg::KIND_MSG;
                r_out_byte   <= r_rd_data[7:0];
                r_out_is_pid <= r_rd_data[8];
                r_out_err    <= j1587_pkg::ERR_UNKNOWN_MID;
                r_out_last   <= drain_end;
            end else if (err_fire) begin
                r_out_valid  <= 1'b1;
                r_out_kind   <= j1587_pkg::KIND_ERR;
                r_out_byte   <= 8'd0;
                r_out_is_pid <= 1'b0;
                r_out_err    <= err_code;
                r_out_last   <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_out_byte   = r_out_byte;
    assign o_is_pid     = r_out_is_pid;
    assign o_error_code = r_out_err;
    assign o_last       = r_out_last;

`ifndef ASSERT_OFF
    a_close_starts_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_fire |=> (r_state == ST_RD) && (r_rd_addr == '0))
        else $error("closed message did not start a drain at the first entry");

    a_drain_end_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_end |=> (r_state == ST_RUN) && r_out_valid && r_out_last)
        else $error("drain did not finish on its last byte");

    a_drain_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> (r_rd_addr <= r_drain_last))
        else $error("drain read beyond the closed message");

    a_body_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_FRAME_BODY) |-> (r_cnt != '0) && (r_cnt <= CW'(MAX_LEN)))
        else $error("message byte count out of range");

    a_error_result_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == j1587_pkg::KIND_ERR)
            |-> r_out_last && (r_out_byte == 8'd0) && !r_out_is_pid)
        else $error("malformed error result");
`endif

endmodule
